// ----- rtl/core/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

  // Width of the base, power and configuration data fields on the ports.
  localparam int unsigned FieldW = 31;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 2;

  // Configuration register map.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPONENT = 2'd0,
    CFG_MODULUS  = 2'd1
  } cfg_idx_e;

endpackage

// ----- rtl/core/mexp_if.sv -----
// Handshake channel interfaces: base input, power output and configuration writes.
`timescale 1ns / 1ps
interface mexp_base_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] base;

  modport source (output valid, output base, input ready);
  modport sink (input valid, input base, output ready);
endinterface

interface mexp_power_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink (input valid, input power, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [FieldW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/mexp_mulmod.sv -----
// Shared modular multiplier: one product, then bit-serial restoring reduction.
`timescale 1ns / 1ps
module mexp_mulmod #(
  parameter int unsigned OperandBits = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [OperandBits-1:0] a_i,
  input  logic [OperandBits-1:0] b_i,
  input  logic [OperandBits-1:0] m_i,
  output logic                   done_o,
  output logic [OperandBits-1:0] res_o
);

  localparam int unsigned ProdW = 2 * OperandBits;
  localparam int unsigned CntW  = $clog2(ProdW);
  localparam logic [CntW-1:0] LastCnt = CntW'(ProdW - 1);

  typedef enum logic {
    MM_IDLE,
    MM_RED
  } mm_state_e;

  mm_state_e              state_q;
  logic [ProdW-1:0]       prod_q;
  logic [OperandBits-1:0] m_q;
  logic [OperandBits-1:0] rem_q;
  logic [CntW-1:0]        cnt_q;
  logic                   done_q;

  logic [OperandBits:0]   trial;
  logic [OperandBits:0]   diff;
  logic [OperandBits-1:0] rem_d;

  // Shift in the next product bit; trial stays below twice the modulus.
  assign trial = {rem_q, prod_q[ProdW-1]};
  assign diff  = trial - {1'b0, m_q};
  assign rem_d = (trial >= {1'b0, m_q}) ? diff[OperandBits-1:0] : trial[OperandBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MM_IDLE: begin
          if (start_i) begin
            prod_q  <= ProdW'(a_i) * ProdW'(b_i);
            m_q     <= m_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= MM_RED;
          end
        end
        MM_RED: begin
          rem_q  <= rem_d;
          prod_q <= {prod_q[ProdW-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            done_q  <= 1'b1;
            state_q <= MM_IDLE;
          end
        end
        default: state_q <= MM_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = rem_q;

endmodule

// ----- rtl/core/modular_exponentiation.sv -----
// Top level: right-to-left square-and-multiply sequencer around the shared mulmod.
// Each modular multiply is issued, forms its product, then reduces one product bit
// per cycle; an item needs up to 2*OPERAND_BITS-1 multiplies, none for exponent 0.
// One item at a time: a new base is taken only while the sequencer is idle.
// Reset: asynchronous, active low; exponent and modulus return to 1, channels empty.
`timescale 1ns / 1ps
module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mexp_cfg_if.sink      cfg_i,
  mexp_base_if.sink     in_i,
  mexp_power_if.source  out_o
);

  localparam int unsigned OpW = OPERAND_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ACC,
    S_SQR,
    S_DONE
  } state_e;

  state_e         state_q;
  logic [OpW-1:0] exponent_q;
  logic [OpW-1:0] modulus_q;

  // Working registers of the current item.
  logic [OpW-1:0] e_q;
  logic [OpW-1:0] m_q;
  logic [OpW-1:0] acc_q;
  logic [OpW-1:0] sq_q;

  // Operands issued to the shared unit.
  logic           mm_start_q;
  logic [OpW-1:0] mm_a_q;
  logic [OpW-1:0] mm_b_q;
  logic           mm_done;
  logic [OpW-1:0] mm_res;

  // Output register: holds a finished power until the sink takes it.
  logic           out_valid_q;
  logic [OpW-1:0] power_q;

  logic           in_xfer;
  logic           cfg_xfer;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;

  // Configuration writes are always taken; writes to unknown indexes drop.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= OpW'(1);
      modulus_q  <= OpW'(1);
    end else if (cfg_xfer) begin
      case (cfg_i.index)
        CFG_EXPONENT: exponent_q <= cfg_i.data[OpW-1:0];
        CFG_MODULUS:  modulus_q  <= cfg_i.data[OpW-1:0];
        default: ;
      endcase
    end
  end

  mexp_mulmod #(
    .OperandBits(OpW)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start_q),
    .a_i    (mm_a_q),
    .b_i    (mm_b_q),
    .m_i    (m_q),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mm_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mm_start_q <= 1'b0;
      // Drop the output once the sink takes it; a new load below overrides.
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            sq_q    <= in_i.base[OpW-1:0];
            e_q     <= exponent_q;
            // A zero modulus behaves as modulus one.
            m_q     <= (modulus_q == '0) ? OpW'(1) : modulus_q;
            acc_q   <= OpW'(1);
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Scan the exponent from its low bit; stop once no set bit is left.
          if (e_q == '0) begin
            state_q <= S_DONE;
          end else if (e_q[0]) begin
            mm_a_q     <= acc_q;
            mm_b_q     <= sq_q;
            mm_start_q <= 1'b1;
            state_q    <= S_ACC;
          end else begin
            mm_a_q     <= sq_q;
            mm_b_q     <= sq_q;
            mm_start_q <= 1'b1;
            state_q    <= S_SQR;
          end
        end
        S_ACC: begin
          if (mm_done) begin
            acc_q <= mm_res;
            // Skip the final squaring when no higher exponent bit needs it.
            if ((e_q >> 1) == '0) begin
              e_q     <= '0;
              state_q <= S_DONE;
            end else begin
              mm_a_q     <= sq_q;
              mm_b_q     <= sq_q;
              mm_start_q <= 1'b1;
              state_q    <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mm_done) begin
            sq_q    <= mm_res;
            e_q     <= e_q >> 1;
            state_q <= S_CHECK;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_q || out_o.ready) begin
            power_q     <= acc_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.power = FieldW'(power_q);

endmodule

// ----- tb/modular_exponentiation_tb.sv -----
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps
module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int unsigned    ClkPeriod    = 12;
  localparam int unsigned    ResetCycles  = 2;
  localparam int unsigned    RandomPhases = 12;
  // Phase whose key uses the full exponent width; those items are slow, keep it short.
  localparam int unsigned    WidePhase    = 5;
  // Phase during which the result side holds off long enough to back up the input.
  localparam int unsigned    HoldPhase    = 3;
  localparam int unsigned    HoldCycles   = 12000;
  localparam int unsigned    TailCycles   = 50;
  // Watchdog bound on the whole run in nanoseconds, with a wide margin over the slowest legal run.
  localparam longint         TimeoutNs    = 50_000_000;
  localparam logic [FieldW-1:0] FieldMax  = '1;

  typedef struct packed {
    logic [FieldW-1:0] base;
    logic [FieldW-1:0] power;
  } power_entry_t;

  logic clk;
  logic rst_n;

  mexp_cfg_if   cfg_if ();
  mexp_base_if  base_if ();
  mexp_power_if power_if ();

  modular_exponentiation i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (base_if),
    .out_o  (power_if)
  );

  // Mirror of the key registers; reset leaves both at 1.
  logic [FieldW-1:0] exponent_q = 1;
  logic [FieldW-1:0] modulus_q  = 1;

  // Bases waiting to be offered, and powers owed by the block in order.
  logic [FieldW-1:0] pending_bases[$];
  power_entry_t      expected_powers[$];

  int unsigned bases_sent     = 0;
  int unsigned powers_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned key_settings   = 1;

  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  bit          hold_request = 1'b0;
  bit          quiet        = 1'b0;
  bit          base_taken   = 1'b0;

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  // Right-to-left square-and-multiply against the mirrored key. A zero exponent
  // yields 1 unreduced; a zero modulus behaves as modulus 1.
  function automatic logic [FieldW-1:0] expected_power(input logic [FieldW-1:0] base_val);
    logic [2*FieldW-1:0] square;
    logic [2*FieldW-1:0] acc;
    logic [2*FieldW-1:0] m;
    logic [FieldW-1:0]   e;
    square = (2*FieldW)'(base_val);
    acc    = 1;
    m      = (2*FieldW)'((modulus_q == '0) ? FieldW'(1) : modulus_q);
    e      = exponent_q;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * square) % m;
      end
      square = (square * square) % m;
      e      = e >> 1;
    end
    return acc[FieldW-1:0];
  endfunction

  // Input side, rising edge: on a transfer, record the owed power and retire the base.
  always @(posedge clk) begin
    if (rst_n && base_if.valid && base_if.ready) begin
      expected_powers.push_back('{base: base_if.base, power: expected_power(base_if.base)});
      void'(pending_bases.pop_front());
      bases_sent++;
      base_taken = 1'b1;
    end
  end

  // Input side, falling edge: hold the current base until it transfers, then
  // advance to the next one, with an occasional burst of idle cycles between.
  always @(negedge clk) begin
    if (rst_n && (!base_if.valid || base_taken)) begin
      base_taken = 1'b0;
      if (send_gap > 0) begin
        base_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_bases.size() > 0) begin
        base_if.valid <= 1'b1;
        base_if.base  <= pending_bases[0];
        if (!quiet && $urandom_range(5, 0) == 0) begin
          send_gap = $urandom_range(7, 1);
        end
      end else begin
        base_if.valid <= 1'b0;
      end
    end
  end

  // Result side, falling edge: drop ready for a long hold when asked, otherwise
  // in short random bursts; keep it high throughout the quiet tail.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        power_if.ready <= 1'b0;
        hold_left--;
      end else if (recv_gap > 0) begin
        power_if.ready <= 1'b0;
        recv_gap--;
      end else begin
        power_if.ready <= 1'b1;
        if (!quiet && $urandom_range(4, 0) == 0) begin
          recv_gap = $urandom_range(7, 1);
        end
      end
    end
  end

  // Result side, rising edge: compare each transfer with the oldest owed power.
  always @(posedge clk) begin : power_monitor
    power_entry_t head;
    if (rst_n && power_if.valid && power_if.ready) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: power %0d arrived with none expected", $time, power_if.power);
        mismatches++;
      end else begin
        head = expected_powers.pop_front();
        powers_checked++;
        if (power_if.power !== head.power) begin
          $display("%0t: base %0d exp %0d mod %0d: expected power %0d, actual %0d",
                   $time, head.base, exponent_q, modulus_q, head.power, power_if.power);
          mismatches++;
        end
      end
    end
  end

  // One register write: offer at the falling edge, wait for the transfer, drop valid.
  task automatic write_reg(input cfg_idx_e idx, input logic [FieldW-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_EXPONENT) begin
      exponent_q = value;
    end else begin
      modulus_q = value;
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_key(input logic [FieldW-1:0] e, input logic [FieldW-1:0] m);
    write_reg(CFG_EXPONENT, e);
    write_reg(CFG_MODULUS, m);
    key_settings++;
  endtask

  // Block until every base has transferred and every power has come back.
  task automatic drain();
    while (pending_bases.size() != 0 || expected_powers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int unsigned       ew;
    int unsigned       mw;
    int unsigned       count;
    logic [FieldW-1:0] e;
    logic [FieldW-1:0] m;
    logic [FieldW-1:0] b;

    rst_n          = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_EXPONENT;
    cfg_if.data    = '0;
    base_if.valid  = 1'b0;
    base_if.base   = '0;
    power_if.ready = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset key: exponent 1, modulus 1, so every power is 0.
    pending_bases = '{0, FieldMax};
    drain();

    // Zero exponent gives 1 unreduced, even against modulus 1; 0^0 is 1 too.
    set_key(0, 1);
    pending_bases = '{5, FieldMax};
    drain();
    set_key(0, FieldMax);
    pending_bases = '{0};
    drain();

    // Bases at and above the modulus must still come back reduced.
    set_key(1, 1000);
    pending_bases = '{999, 1000, FieldMax, 0};
    drain();
    set_key(2, FieldMax);
    pending_bases = '{FieldMax - 1, FieldMax};
    drain();

    // Small RSA-style key on byte-sized messages.
    set_key(65537, 3233);
    pending_bases = '{65, 0, 255, 128};
    drain();

    // Widest exponent and modulus: the longest items the block can see.
    set_key(FieldMax, FieldMax);
    pending_bases = '{2, FieldMax - 1};
    drain();

    // Zero modulus behaves as modulus 1; zero exponent still wins; then modulus 2.
    set_key(5, 0);
    pending_bases = '{7};
    drain();
    set_key(0, 0);
    pending_bases = '{7};
    drain();
    set_key(FieldMax, 2);
    pending_bases = '{3};
    drain();

    // Random keys. Exponents stay narrow to bound the run, except one short phase.
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == WidePhase) begin
        e     = FieldW'($urandom | (1 << (FieldW - 1)));
        count = 6;
      end else begin
        ew    = $urandom_range(16, 0);
        e     = (ew == 0) ? '0 : FieldW'(($urandom & ((1 << ew) - 1)) | (1 << (ew - 1)));
        count = 24;
      end
      case (p)
        0: m = FieldMax;
        1: m = 1;
        2: m = 2;
        default: begin
          mw = $urandom_range(FieldW, 1);
          m  = FieldW'(($urandom & ((64'd1 << mw) - 1)) | (1 << (mw - 1)));
        end
      endcase
      quiet = (p == RandomPhases - 1);
      if (p == HoldPhase) begin
        hold_request = 1'b1;
      end
      set_key(e, m);
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(2, 0))
          0: b = FieldW'($urandom_range(255, 0));
          1: b = (m > 1) ? FieldW'($urandom_range(m - 1, 0)) : '0;
          default: b = FieldW'($urandom);
        endcase
        pending_bases.push_back(b);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d bases under %0d keys, checked %0d powers, %0d mismatches.",
             bases_sent, key_settings, powers_checked, mismatches);
    $display("Keys covered zero and full-width exponents, moduli 0, 1, 2 and maximum.");
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("modular_exponentiation_tb: PASS");
    end else begin
      $display("modular_exponentiation_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("%0t: timeout with %0d bases pending and %0d powers owed",
             $time, pending_bases.size(), expected_powers.size());
    $display("modular_exponentiation_tb: FAIL");
    $finish;
  end

endmodule
